FILE: rtl/core/gcsf_pkg.sv
// ----------------------------------------------------------------------------
// gcsf_pkg: shared types and constants for the grid cell snap block
// Status codes, register indexes, controller states and the divider
// request/response bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcsf_pkg;

    // result status codes
    localparam logic [2:0] STAT_OWN     = 3'd0;
    localparam logic [2:0] STAT_MOVED   = 3'd1;
    localparam logic [2:0] STAT_OUTSIDE = 3'd2;
    localparam logic [2:0] STAT_NONE    = 3'd3;
    localparam logic [2:0] STAT_WRITTEN = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] CFG_CELL_SIZE   = 3'd2;
    localparam logic [2:0] CFG_GRID_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_GRID_HEIGHT = 3'd4;

    // item command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // divider widths: 33-bit magnitude over a 24-bit cell size
    localparam int DIV_W  = 33;
    localparam int DSR_W  = 24;
    localparam int DCNT_W = 6;

    // signed width of a ring candidate coordinate (index 0..63 plus ring up to 64)
    localparam int CW = 9;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DSR_W-1:0]   divisor;
    } gcsf_div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } gcsf_div_rsp_t;

    // controller states, one-hot
    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DIVX  = 8'b0000_0100,
        ST_DIVY  = 8'b0000_1000,
        ST_OWN   = 8'b0001_0000,
        ST_CAND  = 8'b0010_0000,
        ST_CHECK = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } gcsf_state_t;

endpackage

FILE: rtl/core/gcsf_div.sv
// ----------------------------------------------------------------------------
// gcsf_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle for DIV_W quotient bits;
// done pulses for one cycle with the quotient valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcsf_div
    import gcsf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  gcsf_div_req_t req,
    output gcsf_div_rsp_t rsp
);

    logic [DSR_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DSR_W-1:0]  dsr_reg;

    logic [DSR_W:0]    shifted;
    logic              ge;
    logic [DSR_W:0]    sub;

    // one restoring step
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign sub     = shifted - {1'b0, dsr_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? sub[DSR_W-1:0] : shifted[DSR_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/core/grid_cell_snap_to_free.sv
// Write item: the result goes from ST_DONE into the output registers and the block
// returns to ST_IDLE for the next item. Query item: two serial divisions through
// the one divider and one map read, then ST_CAND and ST_CHECK per in-grid ring cell
// and ST_CAND alone per ring cell off the grid (8 per ring, up to max(width, height)
// rings). One item in flight; a result may wait at the output. After reset the map
// is cleared one cell a cycle, all MAX_ROWS*MAX_COLS cells, before any item is taken.
// ----------------------------------------------------------------------------
// grid_cell_snap_to_free: snap a position to a free cell of an occupancy map
// Holds a one-bit free map, converts a fixed-point position to a cell and
// searches outward rings for the nearest free cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_cell_snap_to_free
    import gcsf_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // input items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic [5:0]         write_row,
    input  logic [5:0]         write_col,
    input  logic               write_free,
    // result items
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [5:0]         cell_col,
    output logic [5:0]         cell_row
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    // configuration registers
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;
    logic [23:0]        cell_size_reg;
    logic [6:0]         grid_width_reg;
    logic [6:0]         grid_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            cell_size_reg   <= 24'd256;
            grid_width_reg  <= 7'd64;
            grid_height_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                CFG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                CFG_CELL_SIZE:   cell_size_reg   <= cfg_data[23:0];
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[6:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[6:0];
                default:         ;
            endcase
        end
    end

    // grid size in use, clamped to the map
    logic [6:0] grid_w;
    logic [6:0] grid_h;
    logic [6:0] rings;

    assign grid_w = (int'(grid_width_reg) > MAX_COLS) ? 7'(MAX_COLS) : grid_width_reg;
    assign grid_h = (int'(grid_height_reg) > MAX_ROWS) ? 7'(MAX_ROWS) : grid_height_reg;
    assign rings  = (grid_w > grid_h) ? grid_w : grid_h;

    // state and working registers
    gcsf_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic signed [31:0]  py_reg;
    logic                negx_reg;
    logic                outx_reg;
    logic                negy_reg;
    logic [6:0]          col_reg;
    logic [6:0]          row_reg;
    logic [6:0]          m_reg, m_next;
    logic [2:0]          k_reg, k_next;
    logic [2:0]          res_status_reg, res_status_next;
    logic [6:0]          res_col_reg, res_col_next;
    logic [6:0]          res_row_reg, res_row_next;
    logic                out_valid_reg;
    logic [2:0]          status_reg;
    logic [5:0]          cell_col_reg;
    logic [5:0]          cell_row_reg;

    logic                in_acc;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // magnitude and sign of the offsets from the origin
    logic [DIV_W-1:0] diff_x, diff_y, mag_x, mag_y;

    assign diff_x = {pos_x[31], pos_x} - {origin_x_reg[31], origin_x_reg};
    assign diff_y = {py_reg[31], py_reg} - {origin_y_reg[31], origin_y_reg};
    assign mag_x  = diff_x[DIV_W-1] ? (~diff_x + DIV_W'(1)) : diff_x;
    assign mag_y  = diff_y[DIV_W-1] ? (~diff_y + DIV_W'(1)) : diff_y;

    // shared divider
    gcsf_div_req_t div_req;
    gcsf_div_rsp_t div_rsp;

    gcsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        div_req.start    = (state_reg == ST_IDLE && in_acc && cmd == CMD_QUERY
                            && cell_size_reg != '0)
                           || (state_reg == ST_DIVX && div_rsp.done);
        div_req.dividend = (state_reg == ST_IDLE) ? mag_x : mag_y;
        div_req.divisor  = cell_size_reg;
    end

    // range check of a finished quotient: negative non-zero or past the grid
    logic quo_zero;
    logic outx_now;
    logic outy_now;

    assign quo_zero = (div_rsp.quotient == '0);
    assign outx_now = (negx_reg && !quo_zero) || (div_rsp.quotient >= DIV_W'(grid_w));
    assign outy_now = (negy_reg && !quo_zero) || (div_rsp.quotient >= DIV_W'(grid_h));

    // ring candidate for the current ring and ray
    logic signed [CW-1:0] row_s, col_s, m_s, nr, nc;
    logic                 cand_in;
    logic [6:0]           cand_row, cand_col;

    assign row_s = {2'b00, row_reg};
    assign col_s = {2'b00, col_reg};
    assign m_s   = {2'b00, m_reg};

    always_comb
    begin
        case (k_reg)
            3'd0:    begin nr = row_s - m_s; nc = col_s - m_s; end
            3'd1:    begin nr = row_s - m_s; nc = col_s;       end
            3'd2:    begin nr = row_s - m_s; nc = col_s + m_s; end
            3'd3:    begin nr = row_s;       nc = col_s - m_s; end
            3'd4:    begin nr = row_s;       nc = col_s + m_s; end
            3'd5:    begin nr = row_s + m_s; nc = col_s - m_s; end
            3'd6:    begin nr = row_s + m_s; nc = col_s;       end
            3'd7:    begin nr = row_s + m_s; nc = col_s + m_s; end
            default: begin nr = row_s;       nc = col_s;       end
        endcase
    end

    assign cand_in  = !nr[CW-1] && (nr[CW-2:0] < {1'b0, grid_h})
                      && !nc[CW-1] && (nc[CW-2:0] < {1'b0, grid_w});
    assign cand_row = nr[6:0];
    assign cand_col = nc[6:0];

    // free map memory
    logic              mem [DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_data_reg;
    logic              wr_in_map;

    assign wr_in_map = (int'(write_row) < MAX_ROWS) && (int'(write_col) < MAX_COLS);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = 1'b0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == ST_IDLE && in_acc && cmd == CMD_WRITE && wr_in_map)
        begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(int'(write_row) * MAX_COLS + int'(write_col));
            mem_wdata = write_free;
        end
    end

    always_comb
    begin
        if (state_reg == ST_DIVY)
            rd_addr = ADDR_W'(int'(div_rsp.quotient[6:0]) * MAX_COLS + int'(col_reg));
        else
            rd_addr = ADDR_W'(int'(cand_row) * MAX_COLS + int'(cand_col));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer
    logic last_cand;
    assign last_cand = (k_reg == 3'd7) && (m_reg == rings);

    always_comb
    begin
        state_next      = state_reg;
        m_next          = m_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        res_col_next    = res_col_reg;
        res_row_next    = res_row_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_col_next = '0;
                    res_row_next = '0;
                    if (cmd == CMD_WRITE)
                    begin
                        res_status_next = STAT_WRITTEN;
                        state_next      = ST_DONE;
                    end
                    else if (cell_size_reg == '0)
                    begin
                        res_status_next = STAT_OUTSIDE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIVX;
                    end
                end
            end
            ST_DIVX:
            begin
                if (div_rsp.done)
                    state_next = ST_DIVY;
            end
            ST_DIVY:
            begin
                if (div_rsp.done)
                begin
                    if (outx_reg || outy_now)
                    begin
                        res_status_next = STAT_OUTSIDE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_OWN;
                    end
                end
            end
            ST_OWN:
            begin
                if (rd_data_reg)
                begin
                    res_status_next = STAT_OWN;
                    res_col_next    = col_reg;
                    res_row_next    = row_reg;
                    state_next      = ST_DONE;
                end
                else
                begin
                    m_next     = 7'd1;
                    k_next     = '0;
                    state_next = ST_CAND;
                end
            end
            ST_CAND, ST_CHECK:
            begin
                if (state_reg == ST_CAND && cand_in)
                begin
                    state_next = ST_CHECK;
                end
                else if (state_reg == ST_CHECK && rd_data_reg)
                begin
                    res_status_next = STAT_MOVED;
                    res_col_next    = cand_col;
                    res_row_next    = cand_row;
                    state_next      = ST_DONE;
                end
                else if (last_cand)
                begin
                    res_status_next = STAT_NONE;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_CAND;
                    if (k_reg == 3'd7)
                    begin
                        k_next = '0;
                        m_next = m_reg + 7'd1;
                    end
                    else
                    begin
                        k_next = k_reg + 3'd1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        m_reg          <= m_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_col_reg    <= res_col_next;
        res_row_reg    <= res_row_next;
        if (state_reg == ST_IDLE && in_acc)
        begin
            py_reg   <= pos_y;
            negx_reg <= diff_x[DIV_W-1];
        end
        if (state_reg == ST_DIVX && div_rsp.done)
        begin
            outx_reg <= outx_now;
            col_reg  <= div_rsp.quotient[6:0];
            negy_reg <= diff_y[DIV_W-1];
        end
        if (state_reg == ST_DIVY && div_rsp.done)
            row_reg <= div_rsp.quotient[6:0];
        if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
        begin
            status_reg   <= res_status_reg;
            cell_col_reg <= res_col_reg[5:0];
            cell_row_reg <= res_row_reg[5:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign cell_col  = cell_col_reg;
    assign cell_row  = cell_row_reg;

endmodule

FILE: tb/sv/tb_grid_cell_snap_to_free.sv
// ----------------------------------------------------------------------------
// tb_grid_cell_snap_to_free: self-checking bench for the grid cell snap block
// Drives write and query items through the valid/stall channel, predicts each
// result from a local copy of the map and registers, and compares every
// result field against the oldest outstanding expectation (pinned or predicted).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grid_cell_snap_to_free
    import gcsf_pkg::*;
();

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int MAP_COLS        = 64;
    localparam int MAP_ROWS        = 64;
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 50;
    // covers the map clear after reset (4096 cells) several times over
    localparam int IDLE_LIMIT      = 20000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] col;
        logic [5:0] row;
    } snap_t;

    typedef struct {
        bit                 is_cfg;
        logic [2:0]         reg_idx;
        logic [31:0]        reg_val;
        logic               op;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [5:0]         wr;
        logic [5:0]         wc;
        logic               wf;
        bit                 pinned;
        snap_t              want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [5:0]         write_row;
    logic [5:0]         write_col;
    logic               write_free;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic [5:0]         cell_col;
    logic [5:0]         cell_row;

    // predictor state
    bit                 free_map [0:MAP_ROWS-1][0:MAP_COLS-1];
    logic signed [31:0] cur_origin_x;
    logic signed [31:0] cur_origin_y;
    logic [23:0]        cur_cell_size;
    logic [6:0]         cur_width;
    logic [6:0]         cur_height;

    snap_t              expected_q [$];
    stim_row_t          stim_tab [$];
    int                 fail_count = 0;
    int                 rx_count = 0;
    bit                 gaps_on = 1'b1;

    grid_cell_snap_to_free #(
        .MAX_COLS (MAP_COLS),
        .MAX_ROWS (MAP_ROWS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .write_row  (write_row),
        .write_col  (write_col),
        .write_free (write_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .cell_col   (cell_col),
        .cell_row   (cell_row)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit cell_is_free(input longint r, input longint c,
                                        input longint h, input longint w);
        if (r < 0 || r >= h || c < 0 || c >= w)
            return 1'b0;
        return free_map[r][c];
    endfunction

    function automatic snap_t snap_predict(input logic op,
                                           input logic signed [31:0] px,
                                           input logic signed [31:0] py,
                                           input logic [5:0] wr,
                                           input logic [5:0] wc,
                                           input logic wf);
        snap_t  res;
        longint w;
        longint h;
        longint cs;
        longint col;
        longint row;
        longint rings;
        longint nr;
        longint nc;
        bit     hit;
        res = '0;
        if (op == CMD_WRITE)
        begin
            // writes ignore the grid size; every 6-bit index is inside the map
            free_map[wr][wc] = wf;
            res.status = STAT_WRITTEN;
        end
        else
        begin
            w = (cur_width > MAP_COLS) ? MAP_COLS : cur_width;
            h = (cur_height > MAP_ROWS) ? MAP_ROWS : cur_height;
            res.status = STAT_OUTSIDE;
            if (cur_cell_size != 0)
            begin
                cs  = cur_cell_size;
                // truncation toward zero, as SV integer division does
                col = (longint'(px) - longint'(cur_origin_x)) / cs;
                row = (longint'(py) - longint'(cur_origin_y)) / cs;
                if (row >= 0 && row < h && col >= 0 && col < w)
                begin
                    if (cell_is_free(row, col, h, w))
                    begin
                        res.status = STAT_OWN;
                        res.col    = col[5:0];
                        res.row    = row[5:0];
                    end
                    else
                    begin
                        // ring search: row offset outer, column offset inner
                        res.status = STAT_NONE;
                        hit   = 1'b0;
                        rings = (w > h) ? w : h;
                        for (longint m = 1; m <= rings && !hit; m++)
                            for (int i = -1; i <= 1 && !hit; i++)
                                for (int j = -1; j <= 1 && !hit; j++)
                                    if (!(i == 0 && j == 0))
                                    begin
                                        nr = row + i * m;
                                        nc = col + j * m;
                                        if (cell_is_free(nr, nc, h, w))
                                        begin
                                            hit        = 1'b1;
                                            res.status = STAT_MOVED;
                                            res.col    = nc[5:0];
                                            res.row    = nr[5:0];
                                        end
                                    end
                    end
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        stim_tab.insert(stim_tab.size(), r);
    endfunction

    function automatic void add_write(input logic [5:0] wr, input logic [5:0] wc,
                                      input logic wf);
        stim_row_t r;
        r = '{default: '0};
        r.op     = CMD_WRITE;
        r.wr     = wr;
        r.wc     = wc;
        r.wf     = wf;
        r.pinned = 1'b1;
        r.want   = '{STAT_WRITTEN, 6'd0, 6'd0};
        stim_tab.insert(stim_tab.size(), r);
    endfunction

    function automatic void add_query(input logic signed [31:0] px,
                                      input logic signed [31:0] py,
                                      input bit pinned, input snap_t want);
        stim_row_t r;
        r = '{default: '0};
        r.op     = CMD_QUERY;
        r.px     = px;
        r.py     = py;
        r.pinned = pinned;
        r.want   = want;
        stim_tab.insert(stim_tab.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // Driving helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // coordinate around the grid: a couple of cells either side of it
    function automatic logic signed [31:0] pick_coord(input logic signed [31:0] org,
                                                     input logic [23:0] cs,
                                                     input int n);
        int     cc;
        longint p;
        cc = $urandom_range(0, n + 3);
        cc = cc - 2;
        p  = longint'(org) + longint'(cc) * longint'(cs) + $urandom_range(0, cs - 1);
        return 32'(p);
    endfunction

    task automatic offer(input logic op, input logic signed [31:0] px,
                         input logic signed [31:0] py, input logic [5:0] wr,
                         input logic [5:0] wc, input logic wf,
                         input bit pinned, input snap_t want);
        int    gap;
        snap_t pred;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        pos_x      <= px;
        pos_y      <= py;
        write_row  <= wr;
        write_col  <= wc;
        write_free <= wf;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pred = snap_predict(op, px, py, wr, wc, wf);
        expected_q.insert(expected_q.size(), pinned ? want : pred);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ORIGIN_X:    cur_origin_x  = val;
            CFG_ORIGIN_Y:    cur_origin_y  = val;
            CFG_CELL_SIZE:   cur_cell_size = val[23:0];
            CFG_GRID_WIDTH:  cur_width     = val[6:0];
            CFG_GRID_HEIGHT: cur_height    = val[6:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        logic signed [31:0] ox_now;
        logic signed [31:0] oy_now;
        logic [23:0]        cs_now;
        logic [6:0]         w_now;
        logic [6:0]         h_now;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [5:0]         wr;
        logic [5:0]         wc;
        int                 w_eff;
        int                 h_eff;
        int                 free_pct;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_ORIGIN_X;
        cfg_data   = '0;
        in_valid   = 1'b0;
        cmd        = CMD_WRITE;
        pos_x      = '0;
        pos_y      = '0;
        write_row  = '0;
        write_col  = '0;
        write_free = 1'b0;

        // predictor after reset: every cell occupied, default registers
        foreach (free_map[r, c])
            free_map[r][c] = 1'b0;
        cur_origin_x  = '0;
        cur_origin_y  = '0;
        cur_cell_size = 24'd256;
        cur_width     = 7'd64;
        cur_height    = 7'd64;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        add_query(0, 0, 1, '{STAT_NONE, 6'd0, 6'd0});
        add_write(6'd0, 6'd0, 1'b1);
        add_query(0, 0, 1, '{STAT_OWN, 6'd0, 6'd0});
        add_write(6'd63, 6'd63, 1'b1);
        add_query(63 * 256 + 255, 63 * 256 + 255, 1, '{STAT_OWN, 6'd63, 6'd63});
        add_query(64 * 256, 0, 1, '{STAT_OUTSIDE, 6'd0, 6'd0});
        // just below the origin still truncates to cell 0
        add_query(-255, -1, 1, '{STAT_OWN, 6'd0, 6'd0});
        add_query(-256, 0, 1, '{STAT_OUTSIDE, 6'd0, 6'd0});
        add_query(32'sh7FFF_FFFF, 32'sh8000_0000, 1, '{STAT_OUTSIDE, 6'd0, 6'd0});
        add_write(6'd5, 6'd7, 1'b1);
        add_query(5 * 256 + 100, 5 * 256 + 7, 0, '0);
        add_write(6'd0, 6'd0, 1'b0);
        add_query(10, 10, 0, '0);
        // zero cell size
        add_cfg(CFG_CELL_SIZE, 32'd0);
        add_query(0, 0, 1, '{STAT_OUTSIDE, 6'd0, 6'd0});
        // extreme origin and cell size
        add_cfg(CFG_CELL_SIZE, 32'h00FF_FFFF);
        add_cfg(CFG_ORIGIN_X, 32'h8000_0000);
        add_cfg(CFG_ORIGIN_Y, 32'h8000_0000);
        add_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, '{STAT_OUTSIDE, 6'd0, 6'd0});
        add_query(32'sh8000_0000, 32'sh8000_0000, 0, '0);
        // zero grid width
        add_cfg(CFG_ORIGIN_X, 32'd0);
        add_cfg(CFG_ORIGIN_Y, 32'd0);
        add_cfg(CFG_CELL_SIZE, 32'd256);
        add_cfg(CFG_GRID_WIDTH, 32'd0);
        add_query(0, 0, 1, '{STAT_OUTSIDE, 6'd0, 6'd0});
        // grid larger than the map is clamped
        add_cfg(CFG_GRID_WIDTH, 32'd127);
        add_cfg(CFG_GRID_HEIGHT, 32'd127);
        add_query(63 * 256, 63 * 256, 1, '{STAT_OWN, 6'd63, 6'd63});
        add_query(0, 64 * 256, 1, '{STAT_OUTSIDE, 6'd0, 6'd0});
        // single occupied cell: no ring cell is in the grid
        add_cfg(CFG_GRID_WIDTH, 32'd1);
        add_cfg(CFG_GRID_HEIGHT, 32'd1);
        add_query(0, 0, 1, '{STAT_NONE, 6'd0, 6'd0});

        foreach (stim_tab[k])
        begin
            if (stim_tab[k].is_cfg)
            begin
                wait_drained();
                write_reg(stim_tab[k].reg_idx, stim_tab[k].reg_val);
            end
            else
                offer(stim_tab[k].op, stim_tab[k].px, stim_tab[k].py,
                      stim_tab[k].wr, stim_tab[k].wc, stim_tab[k].wf,
                      stim_tab[k].pinned, stim_tab[k].want);
        end

        // random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    ox_now = 0; oy_now = 0; cs_now = 24'd256; w_now = 7'd8; h_now = 7'd8;
                end
                1:
                begin
                    ox_now = 32'sh8000_0000; oy_now = 32'sh8000_0000;
                    cs_now = 24'hFF_FFFF; w_now = 7'd64; h_now = 7'd64;
                end
                2:
                begin
                    ox_now = 32'sh7FFF_FFFF; oy_now = 32'sh7FFF_F000;
                    cs_now = 24'd1; w_now = 7'd16; h_now = 7'd5;
                end
                3:
                begin
                    ox_now = $urandom; oy_now = $urandom;
                    cs_now = 24'($urandom_range(1, 300)); w_now = 7'd127; h_now = 7'd100;
                end
                7:
                begin
                    ox_now = $urandom; oy_now = $urandom;
                    cs_now = 24'($urandom_range(1, 2000)); w_now = 7'd64; h_now = 7'd1;
                end
                8:
                begin
                    ox_now = $urandom; oy_now = $urandom;
                    cs_now = 24'($urandom_range(1, 2000)); w_now = 7'd1; h_now = 7'd64;
                end
                default:
                begin
                    ox_now = $urandom; oy_now = $urandom;
                    cs_now = 24'($urandom_range(1, 2000));
                    w_now  = 7'($urandom_range(1, 20));
                    h_now  = 7'($urandom_range(1, 20));
                end
            endcase
            wait_drained();
            write_reg(CFG_ORIGIN_X, ox_now);
            write_reg(CFG_ORIGIN_Y, oy_now);
            write_reg(CFG_CELL_SIZE, {8'd0, cs_now});
            write_reg(CFG_GRID_WIDTH, {25'd0, w_now});
            write_reg(CFG_GRID_HEIGHT, {25'd0, h_now});

            gaps_on  = (p % 3) != 2;
            free_pct = $urandom_range(10, 90);
            w_eff    = (w_now > MAP_COLS) ? MAP_COLS : w_now;
            h_eff    = (h_now > MAP_ROWS) ? MAP_ROWS : h_now;

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 99) < 45)
                begin
                    // mostly cells in use, some anywhere in the map
                    wr = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, h_eff - 1));
                    wc = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, w_eff - 1));
                    offer(CMD_WRITE, $urandom, $urandom, wr, wc,
                          $urandom_range(0, 99) < free_pct, 0, '0);
                end
                else
                begin
                    if ($urandom_range(0, 99) < 15)
                    begin
                        px = $urandom;
                        py = $urandom;
                    end
                    else
                    begin
                        px = pick_coord(ox_now, cs_now, w_eff);
                        py = pick_coord(oy_now, cs_now, h_eff);
                    end
                    offer(CMD_QUERY, px, py, 6'($urandom), 6'($urandom), 1'($urandom),
                          0, '0);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall stretches plus periodic long hold-offs
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int hold_cnt;
        int mode_cnt;
        int mode;
        int r;
        int next_hold_at;
        hold_cnt     = 0;
        mode_cnt     = 0;
        mode         = 0;
        next_hold_at = 200;
        out_stall    = 1'b0;
        forever
        begin
            @(negedge clk);
            // long hold-off so the block backs up and stalls its input
            if (rx_count >= next_hold_at)
            begin
                hold_cnt     = 400;
                next_hold_at = next_hold_at + 250;
            end
            if (mode_cnt == 0)
            begin
                mode     = $urandom_range(0, 2);
                mode_cnt = $urandom_range(20, 120);
            end
            mode_cnt--;
            if (hold_cnt == 0 && mode != 0)
            begin
                r = $urandom_range(0, 99);
                if (mode == 2 && r < 8)
                    hold_cnt = $urandom_range(5, 40);
                else if (r < ((mode == 1) ? 20 : 45))
                    hold_cnt = 1;
            end
            if (hold_cnt > 0)
            begin
                out_stall <= 1'b1;
                hold_cnt--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result check against the oldest expected result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        snap_t got;
        snap_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, cell_col, cell_row};
            rx_count++;
            if (expected_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d col %0d row %0d",
                             got.status, got.col, got.row);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got.status !== exp_r.status || got.col !== exp_r.col ||
                    got.row !== exp_r.row)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch on result %0d: expected status %0d col %0d row %0d,",
                                 rx_count, exp_r.status, exp_r.col, exp_r.row,
                                 " got status %0d col %0d row %0d",
                                 got.status, got.col, got.row);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if neither channel moves for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/gcsf_pkg.sv
rtl/core/gcsf_div.sv
rtl/core/grid_cell_snap_to_free.sv
tb/sv/tb_grid_cell_snap_to_free.sv
